FILE: sv/chd_pkg.sv
package chd_pkg;

	// default chunk size counter width
	localparam int CHD_SIZE_BITS = 32;

	// characters of the chunked framing
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_COLON = 8'h3A;

	// decoder phase
	typedef enum logic [3:0] {
		PH_SIZE_FIRST  = 4'd0,
		PH_SIZE_DIGITS = 4'd1,
		PH_SIZE_CR     = 4'd2,
		PH_EXT         = 4'd3,
		PH_EXT_CR      = 4'd4,
		PH_DATA        = 4'd5,
		PH_DATA_CR     = 4'd6,
		PH_DATA_LF     = 4'd7,
		PH_TR_START    = 4'd8,
		PH_TR_START_CR = 4'd9,
		PH_TR_KEY      = 4'd10,
		PH_TR_KEY_CR   = 4'd11,
		PH_TR_VALUE    = 4'd12,
		PH_TR_VALUE_CR = 4'd13,
		PH_DONE        = 4'd14,
		PH_ERROR       = 4'd15
	} phase_t;

	// trailer key names that get checked
	typedef enum logic [1:0] {
		NM_HOST  = 2'd0,
		NM_CLEN  = 2'd1,
		NM_TENC  = 2'd2,
		NM_CTYPE = 2'd3
	} name_idx_t;

	localparam int NAME_COUNT = 4;
	localparam int NAME_W     = 17 * 8;

	localparam logic [NAME_W-1:0] NAME_HOST  = NAME_W'("host");
	localparam logic [NAME_W-1:0] NAME_CLEN  = NAME_W'("content-length");
	localparam logic [NAME_W-1:0] NAME_TENC  = NAME_W'("transfer-encoding");
	localparam logic [NAME_W-1:0] NAME_CTYPE = NAME_W'("content-type");

	// control state apart from the size counter
	typedef struct packed {
		phase_t     phase;
		logic [4:0] key_pos;
		logic [3:0] cand;
		logic       val_seen;
		logic       ct_seen;
	} trl_state_t;

	// one result item
	typedef struct packed {
		logic       body_valid;
		logic [7:0] body_byte;
		logic       done;
		logic       err;
	} step_res_t;

	function automatic logic [4:0] name_len(input name_idx_t idx);
		case (idx)
			NM_HOST:  name_len = 5'd4;
			NM_CLEN:  name_len = 5'd14;
			NM_TENC:  name_len = 5'd17;
			NM_CTYPE: name_len = 5'd12;
			default:  name_len = 5'd0;
		endcase
	endfunction

	// character at a position of a name, zero past its end
	function automatic logic [7:0] name_char(input name_idx_t idx, input logic [4:0] pos);
		logic [NAME_W-1:0] s;
		logic [4:0]        len;
		logic [4:0]        sh;
		case (idx)
			NM_HOST:  s = NAME_HOST;
			NM_CLEN:  s = NAME_CLEN;
			NM_TENC:  s = NAME_TENC;
			NM_CTYPE: s = NAME_CTYPE;
			default:  s = '0;
		endcase
		len = name_len(idx);
		sh  = len - 5'd1 - pos;
		if (pos < len) begin
			name_char = s[{sh, 3'b000} +: 8];
		end else begin
			name_char = 8'h00;
		end
	endfunction

endpackage

FILE: sv/chd_step.sv
module chd_step #(
	parameter int SIZE_BITS = chd_pkg::CHD_SIZE_BITS
) (
	input  chd_pkg::trl_state_t   cur,
	input  logic [SIZE_BITS-1:0]  chunk,
	input  logic [7:0]            c,
	input  logic                  start,
	input  logic                  ct_hdr,
	output chd_pkg::trl_state_t   nxt,
	output logic [SIZE_BITS-1:0]  chunk_nxt,
	output chd_pkg::step_res_t    res
);
	import chd_pkg::*;

	localparam logic [SIZE_BITS-1:0] ONE = SIZE_BITS'(1);

	// hex digit decode: {valid, value}
	function automatic logic [4:0] hex_val(input logic [7:0] b);
		logic [7:0] t;
		if (b >= 8'h30 && b <= 8'h39) begin
			t = b - 8'h30;
			hex_val = {1'b1, t[3:0]};
		end else if (b >= 8'h41 && b <= 8'h46) begin
			t = b - 8'h37;
			hex_val = {1'b1, t[3:0]};
		end else if (b >= 8'h61 && b <= 8'h66) begin
			t = b - 8'h57;
			hex_val = {1'b1, t[3:0]};
		end else begin
			hex_val = 5'd0;
		end
	endfunction

	function automatic logic name_hit(input trl_state_t s, input name_idx_t idx);
		name_hit = s.cand[idx] && (s.key_pos == name_len(idx));
	endfunction

	// one key character: narrow the forbidden-name candidates
	function automatic trl_state_t key_char(input trl_state_t s, input logic [7:0] b);
		trl_state_t r;
		logic [7:0] lc;
		name_idx_t  idx;
		r  = s;
		lc = (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
		for (int i = 0; i < NAME_COUNT; i++) begin
			idx = name_idx_t'(i);
			if (s.key_pos >= name_len(idx) || name_char(idx, s.key_pos) != lc) begin
				r.cand[i] = 1'b0;
			end
		end
		if (s.key_pos != 5'd31) begin
			r.key_pos = s.key_pos + 5'd1;
		end
		return r;
	endfunction

	function automatic trl_state_t end_of_key(input trl_state_t s, input logic hdr);
		trl_state_t r;
		r = s;
		if (name_hit(s, NM_HOST) || name_hit(s, NM_CLEN) || name_hit(s, NM_TENC)) begin
			r.phase = PH_ERROR;
		end else if (name_hit(s, NM_CTYPE) && (hdr || s.ct_seen)) begin
			r.phase = PH_ERROR;
		end else begin
			if (name_hit(s, NM_CTYPE)) begin
				r.ct_seen = 1'b1;
			end
			r.val_seen = 1'b0;
			r.phase    = PH_TR_VALUE;
		end
		return r;
	endfunction

	function automatic trl_state_t key_byte(input trl_state_t s, input logic [7:0] b,
			input logic hdr);
		trl_state_t r;
		r = s;
		if (b == CH_COLON) begin
			if (s.key_pos == 5'd0) begin
				r.phase = PH_ERROR;
			end else begin
				r = end_of_key(s, hdr);
			end
		end else if (b == CH_CR) begin
			r.phase = PH_TR_KEY_CR;
		end else if (b == CH_SP || b == CH_TAB) begin
			r.phase = PH_ERROR;
		end else begin
			r = key_char(s, b);
			r.phase = PH_TR_KEY;
		end
		return r;
	endfunction

	function automatic trl_state_t value_byte(input trl_state_t s, input logic [7:0] b);
		trl_state_t r;
		r = s;
		if (b == CH_CR) begin
			r.phase = PH_TR_VALUE_CR;
		end else begin
			if (b != CH_SP && b != CH_TAB) begin
				r.val_seen = 1'b1;
			end
			r.phase = PH_TR_VALUE;
		end
		return r;
	endfunction

	function automatic trl_state_t new_line(input trl_state_t s);
		trl_state_t r;
		r          = s;
		r.phase    = PH_TR_START;
		r.key_pos  = 5'd0;
		r.cand     = 4'hF;
		r.val_seen = 1'b0;
		return r;
	endfunction

	trl_state_t           s;
	logic [SIZE_BITS-1:0] ch;
	logic [4:0]           hx;
	logic                 bv;

	// next state for one byte
	always_comb begin
		if (start) begin
			s.phase    = PH_SIZE_FIRST;
			s.key_pos  = 5'd0;
			s.cand     = 4'hF;
			s.val_seen = 1'b0;
			s.ct_seen  = 1'b0;
			ch         = '0;
		end else begin
			s  = cur;
			ch = chunk;
		end
		hx        = hex_val(c);
		nxt       = s;
		chunk_nxt = ch;
		bv        = 1'b0;
		case (s.phase)
			PH_SIZE_FIRST, PH_SIZE_DIGITS: begin
				if (hx[4]) begin
					if (ch[SIZE_BITS-1 -: 4] != 4'd0) begin
						nxt.phase = PH_ERROR;
					end else begin
						chunk_nxt = {ch[SIZE_BITS-5:0], hx[3:0]};
						nxt.phase = PH_SIZE_DIGITS;
					end
				end else if (s.phase == PH_SIZE_DIGITS && c == CH_SEMI) begin
					nxt.phase = PH_EXT;
				end else if (s.phase == PH_SIZE_DIGITS && c == CH_CR) begin
					nxt.phase = PH_SIZE_CR;
				end else begin
					nxt.phase = PH_ERROR;
				end
			end
			PH_SIZE_CR, PH_EXT, PH_EXT_CR: begin
				if (s.phase != PH_EXT && c == CH_LF) begin
					if (ch != '0) begin
						nxt.phase = PH_DATA;
					end else begin
						nxt = new_line(s);
					end
				end else if (s.phase == PH_SIZE_CR) begin
					nxt.phase = PH_ERROR;
				end else begin
					nxt.phase = (c == CH_CR) ? PH_EXT_CR : PH_EXT;
				end
			end
			PH_DATA: begin
				bv        = 1'b1;
				chunk_nxt = ch - ONE;
				if (ch == ONE) begin
					nxt.phase = PH_DATA_CR;
				end
			end
			PH_DATA_CR: begin
				nxt.phase = (c == CH_CR) ? PH_DATA_LF : PH_ERROR;
			end
			PH_DATA_LF: begin
				if (c == CH_LF) begin
					nxt.phase = PH_SIZE_FIRST;
					chunk_nxt = '0;
				end else begin
					nxt.phase = PH_ERROR;
				end
			end
			PH_TR_START: begin
				if (c == CH_CR) begin
					nxt.phase = PH_TR_START_CR;
				end else begin
					nxt = key_byte(s, c, ct_hdr);
				end
			end
			PH_TR_START_CR, PH_TR_KEY_CR: begin
				// a lone CR is part of the key
				if (c == CH_LF) begin
					nxt.phase = (s.phase == PH_TR_START_CR) ? PH_DONE : PH_ERROR;
				end else begin
					nxt = key_byte(key_char(s, CH_CR), c, ct_hdr);
				end
			end
			PH_TR_KEY: begin
				nxt = key_byte(s, c, ct_hdr);
			end
			PH_TR_VALUE: begin
				nxt = value_byte(s, c);
			end
			PH_TR_VALUE_CR: begin
				if (c == CH_LF) begin
					if (s.val_seen) begin
						nxt = new_line(s);
					end else begin
						nxt.phase = PH_ERROR;
					end
				end else begin
					s.val_seen = 1'b1;
					nxt = value_byte(s, c);
				end
			end
			default: begin
				// done and error hold until start
			end
		endcase
	end

	// result item
	always_comb begin
		res.body_valid = bv;
		res.body_byte  = bv ? c : 8'h00;
		res.done       = (nxt.phase == PH_DONE);
		res.err        = (nxt.phase == PH_ERROR);
	end

endmodule

FILE: sv/http_chunked_body_decoder_top.sv
// Chunked body decoder: takes one body byte per clock and returns one result per byte
// (payload strobe and byte, sticky done, sticky error). A byte goes into an input
// register, the decode of that byte and the state update are combinational between
// that register and the output register, where the result sits, so a result is
// presented once its byte has moved from the input register to the output register;
// one byte is accepted every clock while the output side keeps up. The output
// register decouples the sides: a new byte can be taken while an earlier result
// waits, as long as the input register is empty. Writing the content-type flag is
// allowed only while the decoder is idle; start_req on the first byte of a body
// clears all decode state but keeps that flag. There is no clearing pass after reset.
module http_chunked_body_decoder_top #(
	parameter int SIZE_BITS = chd_pkg::CHD_SIZE_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       start_req,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       body_valid,
	output logic [7:0] body_byte,
	output logic       done_res,
	output logic       error,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data
);
	import chd_pkg::*;

	logic                 valid_s1;
	logic [7:0]           data_s1;
	logic                 start_s1;
	logic                 valid_s2;
	step_res_t            res_s2;
	trl_state_t           state_q;
	logic [SIZE_BITS-1:0] chunk_q;
	logic                 ct_hdr_q;

	trl_state_t           state_nxt;
	logic [SIZE_BITS-1:0] chunk_nxt;
	step_res_t            res_nxt;
	logic                 out_adv;
	logic                 fire_s1;

	// handshake control
	assign out_adv  = !valid_s2 || out_ready;
	assign fire_s1  = valid_s1 && out_adv;
	assign in_ready = !valid_s1 || out_adv;
	assign cfg_ready = 1'b1;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ct_hdr_q <= 1'b0;
		end else if (cfg_valid) begin
			ct_hdr_q <= cfg_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1  <= data_byte;
			start_s1 <= start_req;
		end
	end

	// decode step
	chd_step #(
		.SIZE_BITS(SIZE_BITS)
	) u_step (
		.cur      (state_q),
		.chunk    (chunk_q),
		.c        (data_s1),
		.start    (start_s1),
		.ct_hdr   (ct_hdr_q),
		.nxt      (state_nxt),
		.chunk_nxt(chunk_nxt),
		.res      (res_nxt)
	);

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase    <= PH_SIZE_FIRST;
			state_q.key_pos  <= 5'd0;
			state_q.cand     <= 4'hF;
			state_q.val_seen <= 1'b0;
			state_q.ct_seen  <= 1'b0;
			chunk_q          <= '0;
		end else if (fire_s1) begin
			state_q <= state_nxt;
			chunk_q <= chunk_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire_s1) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid  = valid_s2;
	assign body_valid = res_s2.body_valid;
	assign body_byte  = res_s2.body_byte;
	assign done_res   = res_s2.done;
	assign error      = res_s2.err;

	// a payload byte never comes with done or error
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.body_valid) |-> (!res_s2.done && !res_s2.err))
		else $error("payload transfer flagged done or error");

	// non-payload results carry a zero byte
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !res_s2.body_valid) |-> (res_s2.body_byte == 8'h00))
		else $error("body byte not zero without payload");

	// error is sticky until start
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && !start_s1 && state_q.phase == PH_ERROR) |=>
		(state_q.phase == PH_ERROR))
		else $error("error state left without start");

endmodule
